>>> sv/wced_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wced_pkg: shared types and constants of the window filter
// Field widths, register indexes, mode codes and the per-item control
// word that travels through the filter pipeline.
// ---------------------------------------------------------------------------
package wced_pkg;

   localparam int KERNEL_SIZE = 3;
   localparam int PIX_W       = 8;
   localparam int TAP_W       = 16;
   localparam int COLUMN_W    = KERNEL_SIZE * PIX_W;
   localparam int LINE_WORD_W = (KERNEL_SIZE - 1) * PIX_W;
   localparam int NUM_TAPS    = KERNEL_SIZE * KERNEL_SIZE;
   localparam int SUM_SHIFT   = 3;

   typedef logic [PIX_W-1:0]    pixel_type;
   typedef logic [COLUMN_W-1:0] column_type;
   typedef logic [TAP_W-1:0]    tap_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_KERNEL_TOP    = 2'd0,
      CSR_KERNEL_MIDDLE = 2'd1,
      CSR_KERNEL_BOTTOM = 2'd2,
      CSR_MODE          = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_CONVOLVE = 2'd0,
      MODE_ERODE    = 2'd1,
      MODE_DILATE   = 2'd2,
      MODE_ZERO     = 2'd3
   } mode_type;

   typedef struct packed {
      logic pixel;
      logic emit;
      logic last;
      logic window_ok;
   } ctrl_type;

endpackage

>>> sv/wced_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wced interfaces: request, response and register write channels
// Each channel moves one transaction at a clock edge with valid and ready
// both high.
// ---------------------------------------------------------------------------
interface wced_req_if;
   logic                   valid;
   logic                   ready;
   wced_pkg::opcode_type   opcode;
   wced_pkg::pixel_type    pixel_in;

   modport source (output valid, output opcode, output pixel_in, input ready);
   modport sink   (input valid, input opcode, input pixel_in, output ready);
endinterface

interface wced_rsp_if;
   logic                   valid;
   logic                   ready;
   wced_pkg::pixel_type    pixel_out;
   logic                   last;

   modport source (output valid, output pixel_out, output last, input ready);
   modport sink   (input valid, input pixel_out, input last, output ready);
endinterface

interface wced_csr_if;
   logic                      valid;
   logic                      ready;
   wced_pkg::csr_index_type   index;
   wced_pkg::column_type      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/wced_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wced_ctrl: frame position, drop and drain counters
// Tracks the raster position of the next pixel, drops the leading results
// of each frame and counts the trailing zeros owed after a frame.
// ---------------------------------------------------------------------------
module wced_ctrl #(
   parameter int  LINE_WIDTH   = 512,
   parameter int  FRAME_HEIGHT = 512,
   localparam int COL_W        = $clog2(LINE_WIDTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 accept,
   input  wced_pkg::opcode_type opcode,
   output logic [COL_W-1:0]     rd_addr,
   output logic [COL_W-1:0]     s1_col,
   output wced_pkg::ctrl_type   s1_info
);

   localparam int ROW_W = $clog2(FRAME_HEIGHT);
   localparam int WAIT  = (LINE_WIDTH * (wced_pkg::KERNEL_SIZE - 1)
                           + wced_pkg::KERNEL_SIZE) / 2;
   localparam int CNT_W = $clog2(WAIT + 1);

   localparam logic [COL_W-1:0] LAST_COL = COL_W'(LINE_WIDTH - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(FRAME_HEIGHT - 1);
   localparam logic [COL_W-1:0] EDGE_COL = COL_W'(wced_pkg::KERNEL_SIZE - 1);
   localparam logic [ROW_W-1:0] EDGE_ROW = ROW_W'(wced_pkg::KERNEL_SIZE - 1);
   localparam logic [CNT_W-1:0] WAIT_CNT = CNT_W'(WAIT);

   logic [COL_W-1:0]   column_ff, column_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [CNT_W-1:0]   skip_ff, skip_in;
   logic [CNT_W-1:0]   drain_ff, drain_in;
   wced_pkg::ctrl_type info;
   wced_pkg::ctrl_type s1_info_ff;
   logic [COL_W-1:0]   s1_col_ff;

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      skip_in   = skip_ff;
      drain_in  = drain_ff;
      info      = '0;
      if (accept) begin
         if (opcode == wced_pkg::OP_DRAIN) begin
            // A drain transaction with nothing owed leaves everything alone.
            if (drain_ff != '0) begin
               info.emit = 1'b1;
               info.last = (drain_ff == CNT_W'(1));
               drain_in  = drain_ff - CNT_W'(1);
            end
         end else begin
            drain_in       = '0;
            info.pixel     = 1'b1;
            info.emit      = (skip_ff == WAIT_CNT);
            info.window_ok = (row_ff >= EDGE_ROW) && (column_ff >= EDGE_COL);
            if (skip_ff != WAIT_CNT) begin
               skip_in = skip_ff + CNT_W'(1);
            end
            if (column_ff == LAST_COL) begin
               column_in = '0;
               if (row_ff == LAST_ROW) begin
                  row_in   = '0;
                  skip_in  = '0;
                  drain_in = WAIT_CNT;
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end else begin
               column_in = column_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff  <= '0;
         row_ff     <= '0;
         skip_ff    <= '0;
         drain_ff   <= '0;
         s1_info_ff <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
         skip_ff   <= skip_in;
         drain_ff  <= drain_in;
         if (adv) begin
            s1_info_ff <= info;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_col_ff <= column_ff;
      end
   end

   assign rd_addr = column_ff;
   assign s1_col  = s1_col_ff;
   assign s1_info = s1_info_ff;

endmodule

>>> sv/wced_line_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wced_line_mem: line store, one word per image column
// Each word holds the two newest lines of its column. One read and one
// write per cycle; the read data is registered.
// ---------------------------------------------------------------------------
module wced_line_mem #(
   parameter int  LINE_WIDTH = 512,
   localparam int ADDR_W     = $clog2(LINE_WIDTH)
) (
   input  logic                                clock,
   input  logic                                adv,
   input  logic [ADDR_W-1:0]                   rd_addr,
   input  logic                                wr_en,
   input  logic [ADDR_W-1:0]                   wr_addr,
   input  logic [wced_pkg::LINE_WORD_W-1:0]    wr_data,
   output logic [wced_pkg::LINE_WORD_W-1:0]    rd_data
);

   logic [wced_pkg::LINE_WORD_W-1:0] mem [LINE_WIDTH];
   logic [wced_pkg::LINE_WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // The read register holds while the pipeline is stalled.
   always_ff @(posedge clock) begin
      if (adv) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/wced_win_alu.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wced_win_alu: window registers and filter arithmetic
// Holds the two previous columns of the window, forms the nine taps,
// reduces them to sum, minimum and maximum and selects the mode result.
// ---------------------------------------------------------------------------
module wced_win_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  wced_pkg::ctrl_type   s1_info,
   input  wced_pkg::column_type cur_col,
   input  wced_pkg::column_type kernel [wced_pkg::KERNEL_SIZE],
   input  wced_pkg::mode_type   mode,
   output logic                 res_valid,
   output wced_pkg::pixel_type  res_pixel,
   output logic                 res_last
);

   localparam int K  = wced_pkg::KERNEL_SIZE;
   localparam int PW = wced_pkg::PIX_W;
   localparam int NT = wced_pkg::NUM_TAPS;

   wced_pkg::column_type m1_ff, m2_ff;
   wced_pkg::column_type win [K];
   wced_pkg::tap_type    tap [NT];
   wced_pkg::tap_type    taps_ff [NT];
   wced_pkg::ctrl_type   s2_info_ff, s3_info_ff;
   wced_pkg::tap_type    acc, acc_ff;
   wced_pkg::pixel_type  lo, hi, lo_ff, hi_ff;

   // Column 0 of the kernel is the leftmost, i.e. the oldest column.
   always_comb begin
      win[0] = m2_ff;
      win[1] = m1_ff;
      win[2] = cur_col;
   end

   // A signed coefficient times an unsigned pixel needs the full tap width.
   always_comb begin
      logic signed [wced_pkg::TAP_W-1:0] prod;
      for (int r = 0; r < K; r++) begin
         for (int k = 0; k < K; k++) begin
            prod = $signed(kernel[r][k*PW +: PW]) * $signed({1'b0, win[k][r*PW +: PW]});
            tap[r*K + k] = wced_pkg::TAP_W'(prod);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1_info.pixel) begin
         m2_ff <= m1_ff;
         m1_ff <= cur_col;
      end
      if (adv) begin
         taps_ff <= tap;
      end
   end

   always_comb begin
      acc = '0;
      lo  = '1;
      hi  = '0;
      for (int i = 0; i < NT; i++) begin
         acc = acc + taps_ff[i];
         if (taps_ff[i][PW-1:0] < lo) begin
            lo = taps_ff[i][PW-1:0];
         end
         if (taps_ff[i][PW-1:0] > hi) begin
            hi = taps_ff[i][PW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         acc_ff <= acc;
         lo_ff  <= lo;
         hi_ff  <= hi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_info_ff <= '0;
         s3_info_ff <= '0;
      end else if (adv) begin
         s2_info_ff <= s1_info;
         s3_info_ff <= s2_info_ff;
      end
   end

   // A negative sum divides to zero or below and clamps to zero, so only
   // non-negative sums need the shift.
   always_comb begin
      res_pixel = '0;
      if (s3_info_ff.window_ok) begin
         case (mode)
            wced_pkg::MODE_CONVOLVE: begin
               if (!acc_ff[wced_pkg::TAP_W-1]) begin
                  res_pixel = acc_ff[wced_pkg::SUM_SHIFT +: PW];
               end
            end
            wced_pkg::MODE_ERODE:  res_pixel = lo_ff;
            wced_pkg::MODE_DILATE: res_pixel = hi_ff;
            wced_pkg::MODE_ZERO:   res_pixel = '0;
            default:               res_pixel = '0;
         endcase
      end
   end

   assign res_valid = s3_info_ff.emit;
   assign res_last  = s3_info_ff.last;

endmodule

>>> sv/window_conv_erode_dilate.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// window_conv_erode_dilate: 3x3 convolve, erode and dilate filter
// Streams a grayscale frame in raster order through a line store and a
// 3x3 window, giving one filtered pixel per input pixel.
// ---------------------------------------------------------------------------
// The block takes one transaction per clock cycle; a stalled response channel
// holds the whole pipeline, and the request channel is ready whenever the
// output register is empty or being emptied. The rate is set by the line
// memory read-modify-write (LINE_WIDTH words of two pixels, one read and one
// write port): a pixel is read when accepted and written back from s1 once
// the pipeline advances. The memory needs no clearing pass after reset: the
// window is forced to zero until its lines have been written in the current
// frame. The user must write configuration registers only while no
// transaction is in flight; the block itself does not enforce it.
module window_conv_erode_dilate #(
   parameter int LINE_WIDTH   = 512,
   parameter int FRAME_HEIGHT = 512
) (
   input  logic      clock,
   input  logic      reset,
   wced_req_if.sink  req_bus,
   wced_rsp_if.source rsp_bus,
   wced_csr_if.sink  csr_bus
);

   localparam int COL_W = $clog2(LINE_WIDTH);
   localparam int PW    = wced_pkg::PIX_W;

   logic                                 adv;
   logic                                 accept;
   logic [COL_W-1:0]                     rd_addr;
   logic [COL_W-1:0]                     s1_col;
   wced_pkg::ctrl_type                   s1_info;
   logic [wced_pkg::LINE_WORD_W-1:0]     rd_data;
   logic [wced_pkg::LINE_WORD_W-1:0]     wr_data;
   logic                                 wr_en;
   wced_pkg::pixel_type                  pixel_s1_ff;
   wced_pkg::column_type                 cur_col;
   wced_pkg::column_type                 kernel_ff [wced_pkg::KERNEL_SIZE];
   wced_pkg::mode_type                   mode_ff;
   logic                                 res_valid;
   wced_pkg::pixel_type                  res_pixel;
   logic                                 res_last;
   logic                                 rsp_valid_ff;
   wced_pkg::pixel_type                  pixel_out_ff;
   logic                                 last_ff;

   assign adv           = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign accept        = req_bus.valid && adv;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < wced_pkg::KERNEL_SIZE; r++) begin
            kernel_ff[r] <= '0;
         end
         mode_ff <= wced_pkg::MODE_CONVOLVE;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            wced_pkg::CSR_KERNEL_TOP:    kernel_ff[0] <= csr_bus.data;
            wced_pkg::CSR_KERNEL_MIDDLE: kernel_ff[1] <= csr_bus.data;
            wced_pkg::CSR_KERNEL_BOTTOM: kernel_ff[2] <= csr_bus.data;
            wced_pkg::CSR_MODE:
               mode_ff <= wced_pkg::mode_type'(csr_bus.data[1:0]);
            default: ;
         endcase
      end
   end

   wced_ctrl #(
      .LINE_WIDTH   (LINE_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .accept  (accept),
      .opcode  (req_bus.opcode),
      .rd_addr (rd_addr),
      .s1_col  (s1_col),
      .s1_info (s1_info)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         pixel_s1_ff <= req_bus.pixel_in;
      end
   end

   // The stored word holds the middle line in its high byte and the newest
   // line in its low byte. The new column shifts both up by one line.
   assign cur_col = {pixel_s1_ff, rd_data[PW-1:0], rd_data[2*PW-1:PW]};
   assign wr_data = {rd_data[PW-1:0], pixel_s1_ff};
   assign wr_en   = adv && s1_info.pixel;

   wced_line_mem #(
      .LINE_WIDTH (LINE_WIDTH)
   ) u_line_mem (
      .clock   (clock),
      .adv     (adv),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (s1_col),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   wced_win_alu u_win_alu (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .s1_info   (s1_info),
      .cur_col   (cur_col),
      .kernel    (kernel_ff),
      .mode      (mode_ff),
      .res_valid (res_valid),
      .res_pixel (res_pixel),
      .res_last  (res_last)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pixel_out_ff <= res_pixel;
         last_ff      <= res_last;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.pixel_out = pixel_out_ff;
   assign rsp_bus.last      = last_ff;

endmodule

>>> sv/wced_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wced_checker: port-level checks of the window filter
// Watches the request and response channels of the top level.
// ---------------------------------------------------------------------------
module wced_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input wced_pkg::pixel_type rsp_pixel_out,
   input logic                rsp_last
);

   // A stalled response transaction keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_out) && $stable(rsp_last))
      else $error("response changed while stalled");

   // The final trailing zero of a frame is always zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_pixel_out == '0)
      else $error("last response carries a non-zero pixel");

   // Requests are only held off by a stalled response.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without response back-pressure");

   // Nothing can reach the output in the first cycle after reset.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

bind window_conv_erode_dilate wced_checker u_wced_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_pixel_out (rsp_bus.pixel_out),
   .rsp_last      (rsp_bus.last)
);

>>> tb/tb_window_conv_erode_dilate.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_window_conv_erode_dilate: self-checking bench for the 3x3 window filter
// Streams the leading rows of a frame and drain ticks into the filter under
// several kernel and mode settings and idle patterns, predicts every
// filtered pixel and trailing zero, and compares each response field by
// field in arrival order.
// ---------------------------------------------------------------------------
module tb_window_conv_erode_dilate;

   localparam int KS = wced_pkg::KERNEL_SIZE;
   localparam int PW = wced_pkg::PIX_W;

   // The block runs at its full line width and frame height. A frame is far
   // longer than the run, so the stimulus covers the skipped lead-in and the
   // first rows in which the whole window lies inside the frame.
   localparam int LINE_W       = 512;
   localparam int FRAME_H      = 512;
   localparam int SKIP_LEN     = (LINE_W * (KS - 1) + KS) / 2;
   localparam int LEAD_PIXELS  = LINE_W * (KS - 1) + 8;
   localparam int SUM_DIVISOR  = 8;
   localparam int PIPE_LATENCY = 4;
   localparam int HOLD_CYCLES  = 60;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      wced_pkg::pixel_type value;
      logic                last;
   } filtered_type;

   logic clock;
   logic reset;

   wced_req_if req_bus ();
   wced_rsp_if rsp_bus ();
   wced_csr_if csr_bus ();

   window_conv_erode_dilate #(
      .LINE_WIDTH   (LINE_W),
      .FRAME_HEIGHT (FRAME_H)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Filter state as the block should hold it.
   wced_pkg::column_type kernel_rows [KS];
   wced_pkg::mode_type   filter_mode;
   wced_pkg::pixel_type  line_mem [KS][LINE_W];
   int                   col_pos;
   int                   row_pos;
   int                   skip_seen;
   int                   drain_owed;
   filtered_type         pending_pixels [$];

   int unsigned  send_idle_pct;
   int unsigned  stall_pct;
   logic         rsp_hold;
   int unsigned  mismatch_count;
   int unsigned  cycle_count;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles, %0d results outstanding",
                  cycle_count, pending_pixels.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // The receiver stalls at random, and without a break while a hold-off runs.
   always @(posedge clock) begin
      rsp_bus.ready <= !rsp_hold && ($urandom_range(99) >= stall_pct);
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Responses are sampled at the falling edge; the transaction completes at
   // the following rising edge.
   initial begin
      filtered_type want;
      forever begin
         @(negedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (pending_pixels.size() == 0) begin
               report_mismatch($sformatf("unexpected result pixel %0h last %0b",
                                         rsp_bus.pixel_out, rsp_bus.last));
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_bus.pixel_out !== want.value)
                  report_mismatch($sformatf("pixel_out %0h, expected %0h",
                                            rsp_bus.pixel_out, want.value));
               if (rsp_bus.last !== want.last)
                  report_mismatch($sformatf("last %0b, expected %0b",
                                            rsp_bus.last, want.last));
            end
         end
      end
   end

   function automatic wced_pkg::pixel_type window_value(input int col);
      logic [wced_pkg::TAP_W-1:0] acc;
      wced_pkg::pixel_type        lo;
      wced_pkg::pixel_type        hi;
      int                         coef;
      int                         tap;
      int                         sum;
      acc = '0;
      lo  = 8'hFF;
      hi  = 8'h00;
      for (int r = 0; r < KS; r++) begin
         for (int k = 0; k < KS; k++) begin
            coef = $signed(kernel_rows[r][PW*k +: PW]);
            tap  = coef * int'(line_mem[r][col - (KS - 1) + k]);
            acc  = acc + tap[wced_pkg::TAP_W-1:0];
            if (tap[PW-1:0] < lo) lo = tap[PW-1:0];
            if (tap[PW-1:0] > hi) hi = tap[PW-1:0];
         end
      end
      case (filter_mode)
         wced_pkg::MODE_CONVOLVE: begin
            sum = $signed(acc);
            sum = sum / SUM_DIVISOR;
            if (sum < 0) sum = 0;
            return sum[PW-1:0];
         end
         wced_pkg::MODE_ERODE:  return lo;
         wced_pkg::MODE_DILATE: return hi;
         default:               return '0;
      endcase
   endfunction

   task automatic track_item(input wced_pkg::opcode_type op, input wced_pkg::pixel_type px);
      wced_pkg::pixel_type value;
      if (op == wced_pkg::OP_DRAIN) begin
         // A drain tick with nothing owed has no effect at all.
         if (drain_owed != 0) begin
            pending_pixels.push_back('{value: '0, last: (drain_owed == 1)});
            drain_owed--;
         end
         return;
      end
      // A pixel abandons any drain still owed and begins the next frame.
      drain_owed = 0;
      for (int s = 0; s < KS - 1; s++)
         line_mem[s][col_pos] = line_mem[s + 1][col_pos];
      line_mem[KS - 1][col_pos] = px;
      value = '0;
      if (row_pos >= KS - 1 && col_pos >= KS - 1)
         value = window_value(col_pos);
      if (col_pos + 1 < LINE_W) begin
         col_pos++;
      end else begin
         col_pos = 0;
         row_pos++;
      end
      if (skip_seen < SKIP_LEN) skip_seen++;
      else pending_pixels.push_back('{value: value, last: 1'b0});
      if (col_pos == 0 && row_pos >= FRAME_H) begin
         row_pos    = 0;
         skip_seen  = 0;
         drain_owed = SKIP_LEN;
      end
   endtask

   task automatic send_item(input wced_pkg::opcode_type op, input wced_pkg::pixel_type px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.opcode   <= op;
      req_bus.pixel_in <= px;
      do @(negedge clock); while (req_bus.ready !== 1'b1);
      @(posedge clock);
      track_item(op, px);
   endtask

   task automatic write_register(input wced_pkg::csr_index_type idx,
                                 input wced_pkg::column_type value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(negedge clock); while (csr_bus.ready !== 1'b1);
      @(posedge clock);
      case (idx)
         wced_pkg::CSR_KERNEL_TOP:    kernel_rows[0] = value;
         wced_pkg::CSR_KERNEL_MIDDLE: kernel_rows[1] = value;
         wced_pkg::CSR_KERNEL_BOTTOM: kernel_rows[2] = value;
         wced_pkg::CSR_MODE:          filter_mode = wced_pkg::mode_type'(value[1:0]);
         default: ;
      endcase
   endtask

   task automatic apply_config(input wced_pkg::column_type top,
                               input wced_pkg::column_type middle,
                               input wced_pkg::column_type bottom,
                               input wced_pkg::mode_type mode);
      write_register(wced_pkg::CSR_KERNEL_TOP, top);
      write_register(wced_pkg::CSR_KERNEL_MIDDLE, middle);
      write_register(wced_pkg::CSR_KERNEL_BOTTOM, bottom);
      write_register(wced_pkg::CSR_MODE, wced_pkg::column_type'(mode));
      csr_bus.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
   endtask

   // Drain ticks that owe nothing leave no trace, so the pipeline may still
   // be busy with one after the last result; let it empty before going on.
   task automatic settle(input int unsigned idle, input int unsigned stall);
      wait_drained();
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      send_idle_pct = idle;
      stall_pct    <= stall;
   endtask

   function automatic wced_pkg::pixel_type random_pixel();
      case ($urandom_range(6))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return wced_pkg::pixel_type'($urandom);
      endcase
   endfunction

   function automatic wced_pkg::column_type random_kernel_row();
      wced_pkg::column_type row;
      for (int k = 0; k < KS; k++) begin
         case ($urandom_range(5))
            0:       row[PW*k +: PW] = 8'h80;
            1:       row[PW*k +: PW] = 8'h7F;
            2:       row[PW*k +: PW] = 8'h00;
            3:       row[PW*k +: PW] = 8'hFF;
            default: row[PW*k +: PW] = wced_pkg::pixel_type'($urandom);
         endcase
      end
      return row;
   endfunction

   // Mostly pixels with now and then a stray drain tick; while a drain is
   // owed, mostly drain ticks and now and then a pixel that cuts it short.
   task automatic stream_items(input int unsigned count);
      int unsigned          done;
      wced_pkg::opcode_type op;
      bit                   owed;
      done = 0;
      while (done < count) begin
         owed = (drain_owed != 0);
         if (owed) op = ($urandom_range(99) < 94) ? wced_pkg::OP_DRAIN : wced_pkg::OP_PIXEL;
         else op = ($urandom_range(99) < 4) ? wced_pkg::OP_DRAIN : wced_pkg::OP_PIXEL;
         send_item(op, random_pixel());
         if (op == wced_pkg::OP_PIXEL || owed) done++;
      end
   endtask

   task automatic configure_random(input wced_pkg::mode_type mode);
      apply_config(random_kernel_row(), random_kernel_row(), random_kernel_row(), mode);
   endtask

   // Fills the lead-in of the frame so that the later tests see windows that
   // lie wholly inside it.
   task automatic test_directed_frame();
      settle(0, 0);
      apply_config(24'h7F807F, 24'h01FF00, 24'h80017F, wced_pkg::MODE_CONVOLVE);
      send_item(wced_pkg::OP_DRAIN, 8'hA5);
      for (int i = 0; i < LEAD_PIXELS; i++)
         send_item(wced_pkg::OP_PIXEL,
                   (i % 3 == 1) ? 8'h00 :
                   (i % 5 == 0) ? wced_pkg::pixel_type'(i * 29) : 8'hFF);
      repeat (3) send_item(wced_pkg::OP_DRAIN, 8'h5A);
      send_item(wced_pkg::OP_PIXEL, 8'hFF);
   endtask

   task automatic test_convolve();
      settle(0, 0);
      configure_random(wced_pkg::MODE_CONVOLVE);
      stream_items(120);
   endtask

   task automatic test_erode();
      settle(81, 0);
      configure_random(wced_pkg::MODE_ERODE);
      stream_items(100);
   endtask

   task automatic test_dilate();
      settle(0, 81);
      configure_random(wced_pkg::MODE_DILATE);
      stream_items(100);
   endtask

   task automatic test_zero_mode();
      settle(37, 37);
      configure_random(wced_pkg::MODE_ZERO);
      stream_items(80);
   endtask

   task automatic test_kernel_extremes();
      settle(0, 0);
      apply_config(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, wced_pkg::MODE_CONVOLVE);
      stream_items(40);
      settle(37, 37);
      apply_config(24'h808080, 24'h808080, 24'h808080, wced_pkg::MODE_CONVOLVE);
      stream_items(40);
      settle(0, 0);
      apply_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, wced_pkg::MODE_DILATE);
      stream_items(40);
      settle(0, 81);
      apply_config(24'h000000, 24'h000000, 24'h000000, wced_pkg::MODE_ERODE);
      stream_items(40);
   endtask

   // The receiver holds off while the sender keeps offering, so the pipeline
   // fills and stops taking input; then the sender waits for every result.
   task automatic test_backpressure();
      settle(0, 0);
      configure_random(wced_pkg::MODE_CONVOLVE);
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         stream_items(100);
      join
      wait_drained();
      stream_items(60);
   endtask

   task automatic test_mixed_settings();
      int unsigned idle_choice [4];
      int unsigned stall_choice [4];
      int unsigned pick;
      idle_choice  = '{0, 81, 0, 37};
      stall_choice = '{0, 0, 81, 37};
      repeat (4) begin
         pick = $urandom_range(3);
         settle(idle_choice[pick], stall_choice[pick]);
         configure_random(wced_pkg::mode_type'($urandom_range(3)));
         stream_items(25);
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.opcode   = wced_pkg::OP_PIXEL;
      req_bus.pixel_in = '0;
      rsp_bus.ready    = 1'b0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = wced_pkg::CSR_KERNEL_TOP;
      csr_bus.data     = '0;
      rsp_hold         = 1'b0;
      send_idle_pct    = 0;
      stall_pct        = 0;
      mismatch_count   = 0;
      cycle_count      = 0;
      for (int r = 0; r < KS; r++) begin
         kernel_rows[r] = '0;
         for (int c = 0; c < LINE_W; c++) line_mem[r][c] = '0;
      end
      filter_mode = wced_pkg::MODE_CONVOLVE;
      col_pos     = 0;
      row_pos     = 0;
      skip_seen   = 0;
      drain_owed  = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed_frame();
      test_convolve();
      test_erode();
      test_dilate();
      test_zero_mode();
      test_kernel_extremes();
      test_backpressure();
      test_mixed_settings();

      wait_drained();
      repeat (4 * PIPE_LATENCY) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
